// ----- sv/bed_pkg.sv -----
// shared types and constants for the backslash escape decoder
package bed_pkg;

  localparam int MaxRun  = 5;
  localparam int RunCntW = 3;
  localparam int ModeW   = 5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       stop_seen;
    logic       run_last;
  } result_t;

  // all result bytes caused by one input item
  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;
    logic [RunCntW-1:0]     cnt;
    logic                   stop;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- sv/backslash_escape_decoder.sv -----
// top level of the backslash escape decoder
//
//   channel  | signals                   | beat taken when
//   ---------+---------------------------+---------------------
//   item     | push, full, item          | push && !full
//   result   | empty, pop, result        | pop && !empty
//   config   | cfg_wr_en, cfg_wr_data    | cfg_wr_en
//
// the front end decodes one text byte per cycle while full is low and queues its result bytes as one run
// a run of n results takes n pop beats; items that cause no result only take the input beat
// input stalls (full high) when QUEUE_DEPTH runs wait in the queue
// reset clears the decoder state and the mode bits and empties the queue
module backslash_escape_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  bed_pkg::item_t            item,
  output logic                      empty,
  input  logic                      pop,
  output bed_pkg::result_t          result,
  input  logic                      cfg_wr_en,
  input  logic [bed_pkg::ModeW-1:0] cfg_wr_data
);

  bed_pkg::run_t   run, head;
  bed_pkg::qstat_t qstat;
  logic            run_wr, rd_en;

  assign full = qstat.full;

  bed_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .item        (item),
    .qstat       (qstat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .run_wr      (run_wr),
    .run         (run)
  );

  bed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (run_wr),
    .wr_run (run),
    .rd_en  (rd_en),
    .head   (head),
    .qstat  (qstat)
  );

  bed_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .empty  (empty),
    .result (result),
    .rd_en  (rd_en)
  );

endmodule

// ----- sv/bed_front.sv -----
// front end: escape decoding state machine, builds one run of result bytes per item
module bed_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bed_pkg::item_t             item,
  input  bed_pkg::qstat_t            qstat,
  input  logic                       cfg_wr_en,
  input  logic [bed_pkg::ModeW-1:0]  cfg_wr_data,
  output logic                       run_wr,
  output bed_pkg::run_t              run
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ESC  = 7'b0000010,
    ST_CTRL = 7'b0000100,
    ST_HEX  = 7'b0001000,
    ST_UNI  = 7'b0010000,
    ST_OCT  = 7'b0100000,
    ST_STOP = 7'b1000000
  } mode_t;

  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChC      = 8'h63;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChUpU    = 8'h55;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7a;
  localparam logic [7:0] ChEsc    = 8'h1b;

  localparam int BitStop = 0;
  localparam int BitCtrl = 1;
  localparam int BitE    = 2;
  localparam int BitHex  = 3;
  localparam int BitOct  = 4;

  logic [bed_pkg::ModeW-1:0] mode_bits;
  mode_t       mode, mode_next;
  logic [31:0] value, value_next;
  logic [3:0]  dcount, dcount_next;
  logic        long_u, long_u_next;
  logic        accept;

  function automatic bed_pkg::run_t add_byte(bed_pkg::run_t r, logic [7:0] b);
    bed_pkg::run_t o;
    o = r;
    if (r.cnt < bed_pkg::RunCntW'(bed_pkg::MaxRun)) begin
      o.bytes[r.cnt] = b;
      o.cnt = r.cnt + 1'b1;
    end
    return o;
  endfunction

  function automatic bed_pkg::run_t add_utf8(bed_pkg::run_t r, logic [31:0] cp);
    bed_pkg::run_t o;
    o = r;
    if (cp < 32'h80) begin
      o = add_byte(o, cp[7:0]);
    end else if (cp < 32'h800) begin
      o = add_byte(o, 8'hc0 | cp[13:6]);
      o = add_byte(o, {2'b10, cp[5:0]});
    end else if (cp < 32'h10000) begin
      o = add_byte(o, 8'he0 | cp[19:12]);
      o = add_byte(o, {2'b10, cp[11:6]});
      o = add_byte(o, {2'b10, cp[5:0]});
    end else begin
      o = add_byte(o, 8'hf0 | cp[25:18]);
      o = add_byte(o, {2'b10, cp[17:12]});
      o = add_byte(o, {2'b10, cp[11:6]});
      o = add_byte(o, {2'b10, cp[5:0]});
    end
    return o;
  endfunction

  // pending escape at end of text or on a non-digit
  function automatic bed_pkg::run_t flush(bed_pkg::run_t r, mode_t m, logic [31:0] v,
                                          logic [3:0] dc, logic lu);
    bed_pkg::run_t o;
    o = r;
    unique case (m)
      ST_ESC: o = add_byte(o, ChBslash);
      ST_CTRL: begin
        o = add_byte(o, ChBslash);
        o = add_byte(o, ChC);
      end
      ST_HEX: begin
        if (dc == 4'd0) begin
          o = add_byte(o, ChBslash);
          o = add_byte(o, ChX);
        end else begin
          o = add_byte(o, v[7:0]);
        end
      end
      ST_UNI: begin
        if (dc == 4'd0) begin
          o = add_byte(o, ChBslash);
          o = add_byte(o, lu ? ChUpU : ChLowU);
        end else begin
          o = add_utf8(o, v);
        end
      end
      ST_OCT: o = add_byte(o, v[7:0]);
      default: o = r;
    endcase
    return o;
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) h = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      h = {1'b1, c[3:0] + 4'd9};
    return h;
  endfunction

  assign accept = push && !qstat.full;

  always_comb begin
    bed_pkg::run_t r;
    logic [7:0]    b;
    logic [4:0]    h;
    logic          stopped;
    logic          unknown;
    r = '0;
    b = item.text_byte;
    h = hex_digit(b);
    stopped = 1'b0;
    unknown = 1'b0;
    mode_next   = mode;
    value_next  = value;
    dcount_next = dcount;
    long_u_next = long_u;

    unique case (mode)
      ST_ESC: begin
        mode_next   = ST_IDLE;
        value_next  = '0;
        dcount_next = '0;
        long_u_next = 1'b0;
        unique case (b) inside
          ChBslash: r = add_byte(r, ChBslash);
          8'h61:    r = add_byte(r, 8'd7);
          8'h62:    r = add_byte(r, 8'd8);
          8'h66:    r = add_byte(r, 8'd12);
          8'h6e:    r = add_byte(r, 8'd10);
          8'h72:    r = add_byte(r, 8'd13);
          8'h74:    r = add_byte(r, 8'd9);
          8'h76:    r = add_byte(r, 8'd11);
          ChC: begin
            if (mode_bits[BitStop]) begin
              r.cnt  = bed_pkg::RunCntW'(1);
              r.stop = 1'b1;
              mode_next = ST_STOP;
            end else if (mode_bits[BitCtrl]) begin
              mode_next = ST_CTRL;
            end else begin
              unknown = 1'b1;
            end
          end
          8'h65, 8'h45: begin
            if (mode_bits[BitE]) r = add_byte(r, ChEsc);
            else unknown = 1'b1;
          end
          8'h22, 8'h27, 8'h3f: begin
            if (mode_bits[BitHex]) r = add_byte(r, b);
            else unknown = 1'b1;
          end
          ChX: begin
            if (mode_bits[BitHex]) mode_next = ST_HEX;
            else unknown = 1'b1;
          end
          ChLowU, ChUpU: begin
            if (mode_bits[BitHex]) begin
              mode_next   = ST_UNI;
              long_u_next = (b == ChUpU);
            end else begin
              unknown = 1'b1;
            end
          end
          default: unknown = 1'b1;
        endcase
        if (unknown) begin
          if (b == ChZero) begin
            mode_next = ST_OCT;
          end else if (mode_bits[BitOct] && b >= ChOne && b <= ChSeven) begin
            mode_next   = ST_OCT;
            value_next  = {29'd0, b[2:0]};
            dcount_next = 4'd1;
          end else begin
            r = add_byte(r, ChBslash);
            r = add_byte(r, b);
          end
        end
      end
      ST_CTRL: begin
        r = add_byte(r, ((b >= ChLowA && b <= ChLowZ) ? b - 8'd32 : b) ^ 8'h40);
        mode_next   = ST_IDLE;
        value_next  = '0;
        dcount_next = '0;
        long_u_next = 1'b0;
      end
      ST_HEX, ST_UNI, ST_OCT: begin
        if ((mode == ST_OCT) ? (b >= ChZero && b <= ChSeven) : h[4]) begin
          value_next  = (mode == ST_OCT) ? {value[28:0], b[2:0]} : {value[27:0], h[3:0]};
          dcount_next = dcount + 4'd1;
          if ((mode == ST_HEX && dcount_next == 4'd2) ||
              (mode == ST_OCT && dcount_next == 4'd3) ||
              (mode == ST_UNI && dcount_next == (long_u ? 4'd8 : 4'd4))) begin
            if (mode == ST_UNI) r = add_utf8(r, value_next);
            else r = add_byte(r, value_next[7:0]);
            mode_next   = ST_IDLE;
            value_next  = '0;
            dcount_next = '0;
            long_u_next = 1'b0;
          end
        end else begin
          r = flush(r, mode, value, dcount, long_u);
          value_next  = '0;
          dcount_next = '0;
          long_u_next = 1'b0;
          if (b == ChBslash) mode_next = ST_ESC;
          else begin
            mode_next = ST_IDLE;
            r = add_byte(r, b);
          end
        end
      end
      ST_STOP: begin
        // text after a stop is dropped up to its final beat
        stopped = 1'b1;
        if (item.final_byte) mode_next = ST_IDLE;
      end
      default: begin
        if (b == ChBslash) mode_next = ST_ESC;
        else begin
          mode_next = ST_IDLE;
          r = add_byte(r, b);
        end
      end
    endcase

    if (item.final_byte && !stopped) begin
      if (mode_next != ST_STOP) r = flush(r, mode_next, value_next, dcount_next, long_u_next);
      mode_next   = ST_IDLE;
      value_next  = '0;
      dcount_next = '0;
      long_u_next = 1'b0;
    end
    run = r;
  end

  assign run_wr = accept && (run.cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= ST_IDLE;
      value     <= '0;
      dcount    <= '0;
      long_u    <= 1'b0;
      mode_bits <= '0;
    end else begin
      if (accept) begin
        mode   <= mode_next;
        value  <= value_next;
        dcount <= dcount_next;
        long_u <= long_u_next;
      end
      if (cfg_wr_en) mode_bits <= cfg_wr_data;
    end
  end

  a_stop_drops: assert property (@(posedge clk) disable iff (rst)
    accept && mode == ST_STOP |-> !run_wr)
    else $error("result produced for a byte dropped after a stop");

endmodule

// ----- sv/bed_queue.sv -----
// short queue of decoded runs between the front and back ends
module bed_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  bed_pkg::run_t   wr_run,
  input  logic            rd_en,
  output bed_pkg::run_t   head,
  output bed_pkg::qstat_t qstat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  bed_pkg::run_t       slots [DEPTH];
  logic [PtrW-1:0]     wr_ptr, rd_ptr;
  logic [CntW-1:0]     count;

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == CntW'(DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wrap_inc(wr_ptr);
      if (rd_en) rd_ptr <= wrap_inc(rd_ptr);
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !qstat.full)
    else $error("write into a full run queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !qstat.empty)
    else $error("read from an empty run queue");

endmodule

// ----- sv/bed_back.sv -----
// back end: walks the head run and hands out one result beat per pop
module bed_back (
  input  logic            clk,
  input  logic            rst,
  input  bed_pkg::run_t   head,
  input  bed_pkg::qstat_t qstat,
  input  logic            pop,
  output logic            empty,
  output bed_pkg::result_t result,
  output logic            rd_en
);

  logic [bed_pkg::RunCntW-1:0] idx;
  logic                        last;

  assign last  = (idx == head.cnt - 1'b1);
  assign empty = qstat.empty;
  assign rd_en = pop && !qstat.empty && last;

  always_comb begin
    result.out_byte   = head.bytes[idx];
    result.byte_valid = !head.stop;
    result.stop_seen  = head.stop;
    result.run_last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop && !qstat.empty) begin
      idx <= last ? '0 : idx + 1'b1;
    end
  end

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    !qstat.empty |-> head.cnt != '0 &&
                     head.cnt <= bed_pkg::RunCntW'(bed_pkg::MaxRun) && idx < head.cnt)
    else $error("head run length out of range");

  a_stop_alone: assert property (@(posedge clk) disable iff (rst)
    !qstat.empty && head.stop |-> head.cnt == bed_pkg::RunCntW'(1) &&
                                   head.bytes[0] == 8'd0)
    else $error("stop run carries data bytes");

endmodule
